// ----- rtl/skct_pkg.sv -----
// Shared types and codes for the sorted key count table.
package skct_pkg;

    localparam int MAJ_W  = 10;
    localparam int KEY_W  = 11;
    localparam int CNT_W  = 16;
    localparam int POS_W  = 9;
    localparam int IDX_W  = 8;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    // Action codes (s_tuser)
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // Status codes (m_tuser)
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_COUNTED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_READ_OK  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_READ_OOR = 3'd4;
    localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd5;

    localparam logic signed [KEY_W-1:0] KEY_ABSENT = '1;
    localparam logic [CNT_W-1:0]        COUNT_MAX  = '1;

    // One table entry
    typedef struct packed {
        logic [MAJ_W-1:0]        major;
        logic signed [KEY_W-1:0] minor;
        logic signed [KEY_W-1:0] net;
        logic [CNT_W-1:0]        count;
    } entry_t;

    // Controller to ring: shift strobe and the entry fed into the tail cell
    typedef struct packed {
        logic   shift;
        entry_t tail;
    } ring_ctl_t;

endpackage

// ----- rtl/skct_cell.sv -----
// One ring cell: holds a table entry and takes its neighbor's entry on shift.
module skct_cell
    import skct_pkg::*;
(
    input  logic   aclk,
    input  logic   shift_en,
    input  entry_t d_in,
    output entry_t q_out
);

    entry_t entry_reg, entry_next;

    // load from neighbor while the ring turns
    always_comb begin
        entry_next = shift_en ? d_in : entry_reg;
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q_out = entry_reg;

endmodule

// ----- rtl/skct_ctrl.sv -----
// Head controller: walks the ring once per add or read request, inserts, counts, reads, clears.
module skct_ctrl
    import skct_pkg::*;
#(
    parameter int NUM_ENTRIES = 256
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [ACT_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic [STAT_W-1:0]     m_tuser,
    input  entry_t                head,
    output ring_ctl_t             ctl
);

    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int KW = $clog2(NUM_ENTRIES);
    localparam logic [KW-1:0] K_LAST = KW'(NUM_ENTRIES - 1);
    localparam logic [CW-1:0] T_FULL = CW'(NUM_ENTRIES);
    localparam int PAD_W = M_DATA_W - (2 * POS_W + MAJ_W + 2 * KEY_W + CNT_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // ordering rule: does the new key go before this entry
    function automatic logic key_less(input entry_t k, input entry_t e);
        logic sec;
        sec = (k.minor != KEY_ABSENT) ? (k.minor < e.minor)
            : ((k.net != KEY_ABSENT) && (k.net < e.net));
        return (k.major < e.major) || ((k.major == e.major) && sec);
    endfunction

    // match rule: same major and same present secondary key
    function automatic logic key_equal(input entry_t k, input entry_t e);
        logic sec;
        sec = (k.minor != KEY_ABSENT) ? (k.minor == e.minor)
            : ((k.net != KEY_ABSENT) && (k.net == e.net));
        return (k.major == e.major) && sec;
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    entry_t              key_reg, key_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [KW-1:0]       k_reg, k_next;
    logic                decided_reg, decided_next;
    logic                shifting_reg, shifting_next;
    logic                ins_reg, ins_next;
    entry_t              carry_reg, carry_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;
    entry_t              res_entry_reg, res_entry_next;
    logic [CW-1:0]       total_reg, total_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                in_fire;
    logic [CW-1:0]       k_ext;
    logic                k_valid;
    entry_t              bumped;
    entry_t              fin_entry;
    logic [STAT_W-1:0]   fin_status;
    logic [POS_W-1:0]    fin_pos;
    logic [CW-1:0]       fin_total;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign k_ext    = CW'(k_reg);
    assign k_valid  = (k_ext < total_reg);

    // head entry with its count bumped, saturating
    always_comb begin
        bumped = head;
        if (head.count != COUNT_MAX) begin
            bumped.count = head.count + 1'b1;
        end
    end

    // sequencer and head processing
    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        decided_next    = decided_reg;
        shifting_next   = shifting_reg;
        ins_next        = ins_reg;
        carry_next      = carry_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_entry_next  = res_entry_reg;
        total_next      = total_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ctl.shift       = (state_reg == ST_RUN);
        ctl.tail        = head;
        fin_entry       = res_entry_reg;
        fin_status      = res_status_reg;
        fin_pos         = res_pos_reg;
        fin_total       = total_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    act_next       = s_tuser;
                    key_next.major = s_tdata[9:0];
                    key_next.minor = s_tdata[20:10];
                    key_next.net   = s_tdata[31:21];
                    key_next.count = CNT_W'(1);
                    idx_next       = s_tdata[39:32];
                    k_next         = '0;
                    decided_next   = 1'b0;
                    shifting_next  = 1'b0;
                    ins_next       = 1'b0;
                    res_pos_next   = '0;
                    res_entry_next = '0;
                    case (s_tuser)
                        ACT_ADD: begin
                            state_next = ST_RUN;
                        end
                        ACT_READ: begin
                            state_next   = ST_RUN;
                            res_pos_next = POS_W'(s_tdata[39:32]);
                            if ((32'(s_tdata[39:32]) < 32'(total_reg)) &&
                                (32'(s_tdata[39:32]) < NUM_ENTRIES)) begin
                                res_status_next = STAT_READ_OK;
                            end else begin
                                res_status_next = STAT_READ_OOR;
                            end
                        end
                        ACT_CLEAR: begin
                            state_next      = ST_DONE;
                            res_status_next = STAT_CLEARED;
                        end
                        default: begin
                            // unused code: dropped without a result
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RUN: begin
                k_next = k_reg + 1'b1;
                if (k_reg == K_LAST) begin
                    state_next = ST_DONE;
                end
                if (act_reg == ACT_READ) begin
                    // grab the entry as it passes the head
                    if ((32'(k_reg) == 32'(idx_reg)) && (res_status_reg == STAT_READ_OK)) begin
                        res_entry_next = head;
                    end
                end else if (shifting_reg) begin
                    // behind an insert: every entry moves up one place
                    ctl.tail   = carry_reg;
                    carry_next = head;
                end else if (!decided_reg) begin
                    if (k_valid && key_equal(key_reg, head)) begin
                        ctl.tail        = bumped;
                        decided_next    = 1'b1;
                        res_status_next = STAT_COUNTED;
                        res_pos_next    = POS_W'(k_reg);
                        res_entry_next  = bumped;
                    end else if (k_valid && key_less(key_reg, head)) begin
                        decided_next = 1'b1;
                        res_pos_next = POS_W'(k_reg);
                        if (total_reg == T_FULL) begin
                            res_status_next = STAT_DROPPED;
                            res_entry_next  = '0;
                        end else begin
                            ctl.tail        = key_reg;
                            carry_next      = head;
                            shifting_next   = 1'b1;
                            ins_next        = 1'b1;
                            res_status_next = STAT_INSERTED;
                            res_entry_next  = key_reg;
                        end
                    end else if (k_ext == total_reg) begin
                        // append after the last valid entry
                        ctl.tail        = key_reg;
                        decided_next    = 1'b1;
                        ins_next        = 1'b1;
                        res_status_next = STAT_INSERTED;
                        res_pos_next    = POS_W'(k_reg);
                        res_entry_next  = key_reg;
                    end
                end
            end

            ST_DONE: begin
                // add that found no place in a full table
                if ((act_reg == ACT_ADD) && !decided_reg) begin
                    fin_status = STAT_DROPPED;
                    fin_pos    = POS_W'(total_reg);
                    fin_entry  = '0;
                end
                if (act_reg == ACT_CLEAR) begin
                    fin_total = '0;
                end else if ((act_reg == ACT_ADD) && ins_reg) begin
                    fin_total = total_reg + 1'b1;
                end
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = fin_status;
                    m_tdata_next  = {PAD_W'(0), POS_W'(fin_total), fin_entry.count,
                                     fin_entry.net, fin_entry.minor, fin_entry.major,
                                     fin_pos};
                    total_next    = fin_total;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            decided_reg  <= 1'b0;
            shifting_reg <= 1'b0;
            ins_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
            decided_reg  <= decided_next;
            shifting_reg <= shifting_next;
            ins_reg      <= ins_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        carry_reg      <= carry_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_entry_reg  <= res_entry_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/sorted_key_count_table.sv -----
// One request at a time: an add or read turns the cell ring once, and the next request is taken
// only after its result has been registered for output; a clear does not walk the ring.
// Reset (aresetn low, synchronous): table empty, no result pending; cell contents
// are left undefined and need no clearing pass.
// Top level: ring of entry cells with the walk controller at its head.
module sorted_key_count_table
    import skct_pkg::*;
#(
    parameter int NUM_ENTRIES = 256
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // key_major[9:0], key_minor[20:10], key_net[31:21], read_index[39:32]
    input  logic [S_DATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [ACT_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // position[8:0], entry_major[18:9], entry_minor[29:19], entry_net[40:30],
    // entry_count[56:41], occupancy[65:57]
    output logic [M_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [STAT_W-1:0]   m_tuser
);

    ring_ctl_t ctl;
    entry_t    ring_q [NUM_ENTRIES];

    skct_ctrl #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .head     (ring_q[0]),
        .ctl      (ctl)
    );

    // cells pass toward the head; the controller feeds the tail
    for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
        if (i == NUM_ENTRIES - 1) begin : g_tail
            skct_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctl.shift),
                .d_in     (ctl.tail),
                .q_out    (ring_q[i])
            );
        end else begin : g_body
            skct_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctl.shift),
                .d_in     (ring_q[i+1]),
                .q_out    (ring_q[i])
            );
        end
    end

endmodule

// ----- rtl/skct_checker.sv -----
// Port-level checks for the sorted key count table, bound to the top level.
module skct_checker
    import skct_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [ACT_W-1:0]    s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]   m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an add or read request occupies the block for the ring walk
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_ADD || s_tuser == ACT_READ) |=> !s_tready)
        else $error("request taken during a ring walk");

    // clear reports an empty table
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_CLEARED) |-> (m_tdata[65:57] == '0) && (m_tdata[8:0] == '0))
        else $error("clear result not empty");

    // dropped and out of range results carry no entry
    a_noentry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_DROPPED || m_tuser == STAT_READ_OOR)
        |-> (m_tdata[56:9] == '0))
        else $error("entry fields set on empty result");

    // counted or inserted entry has a nonzero count
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_COUNTED || m_tuser == STAT_INSERTED)
        |-> (m_tdata[56:41] != '0))
        else $error("touched entry has zero count");

endmodule

bind sorted_key_count_table skct_checker u_skct_checker (.*);
